// ===== hdl/lbs_pkg.sv =====
// Shared types, constants and helpers for the largest blob size block.
package lbs_pkg;

    localparam int CFG_W   = 7;
    localparam int OUT_W   = 13;
    localparam int PADDR_W = 3;
    localparam int APB_W   = 32;

    localparam logic [CFG_W-1:0] GRID_DIM_RST = 7'd64;
    localparam logic [OUT_W-1:0] SIZE_SAT     = 13'h1FFF;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_POP,
        S_POP_WAIT,
        S_NB,
        S_NB_CHK,
        S_DONE
    } t_srch_state;

    typedef enum logic [1:0] {
        STEP_ZERO,
        STEP_INC,
        STEP_DEC
    } t_step;

    typedef struct packed {
        logic active;
        logic done;
    } t_srch_stat;

    typedef struct packed {
        logic grid_we;
        logic vis_we;
        logic grid_d;
        logic vis_d;
    } t_mem_wr;

    // Row step of neighbor k.
    function automatic t_step nb_dr(input logic [2:0] k);
        t_step s;
        case (k)
            3'd0: s = STEP_INC;
            3'd1: s = STEP_DEC;
            3'd2: s = STEP_ZERO;
            3'd3: s = STEP_ZERO;
            3'd4: s = STEP_INC;
            3'd5: s = STEP_DEC;
            3'd6: s = STEP_DEC;
            3'd7: s = STEP_INC;
            default: s = STEP_ZERO;
        endcase
        return s;
    endfunction

    // Column step of neighbor k.
    function automatic t_step nb_dc(input logic [2:0] k);
        t_step s;
        case (k)
            3'd0: s = STEP_ZERO;
            3'd1: s = STEP_ZERO;
            3'd2: s = STEP_INC;
            3'd3: s = STEP_DEC;
            3'd4: s = STEP_INC;
            3'd5: s = STEP_DEC;
            3'd6: s = STEP_INC;
            3'd7: s = STEP_DEC;
            default: s = STEP_ZERO;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/lbs_cell_mem.sv =====
// Grid and visited bit memories, one write port and one registered read port each.
module lbs_cell_mem #(
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  lbs_pkg::t_mem_wr i_wr,
    input  logic [AW-1:0]   i_waddr,
    input  logic [AW-1:0]   i_raddr,
    output logic            o_grid_q,
    output logic            o_vis_q
);

    logic r_grid [DEPTH];
    logic r_vis  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.grid_we) begin
            r_grid[i_waddr] <= i_wr.grid_d;
        end
        o_grid_q <= r_grid[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.vis_we) begin
            r_vis[i_waddr] <= i_wr.vis_d;
        end
        o_vis_q <= r_vis[i_raddr];
    end

endmodule

// ===== hdl/lbs_stack.sv =====
// Search stack: memory of cell entries with a depth counter.
module lbs_stack #(
    parameter int DEPTH = 4096,
    parameter int DW = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_depth;
    logic [CW-1:0] n_depth;
    logic [AW-1:0] w_top;

    assign w_top   = AW'(r_depth - CW'(1));
    assign o_empty = (r_depth == '0);

    always_comb begin
        n_depth = r_depth;
        if (i_push) begin
            n_depth = r_depth + CW'(1);
        end else if (i_pop) begin
            n_depth = r_depth - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[AW'(r_depth)] <= i_wdata;
        end
        if (i_pop) begin
            o_rdata <= r_mem[w_top];
        end
    end

endmodule

// ===== hdl/lbs_search.sv =====
// Component search sequencer: raster scan, stack walk and shared neighbor address unit.
module lbs_search #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    localparam int CELLS = MAX_ROWS * MAX_COLS,
    localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int CW  = $clog2(CELLS + 1),
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [lbs_pkg::CFG_W-1:0] i_rows,
    input  logic [lbs_pkg::CFG_W-1:0] i_cols,
    input  logic [CW-1:0]             i_total,
    input  logic                      i_grid_q,
    input  logic                      i_vis_q,
    output logic [AW-1:0]             o_raddr,
    output logic [AW-1:0]             o_waddr,
    output logic                      o_vis_we,
    output lbs_pkg::t_srch_stat       o_stat,
    output logic [CW-1:0]             o_best
);

    localparam int EW = AW + RW + CLW;
    localparam int MW = (RW > CLW) ? RW : CLW;
    localparam int XW = ((MW > lbs_pkg::CFG_W) ? MW : lbs_pkg::CFG_W) + 1;

    lbs_pkg::t_srch_state r_state, n_state;

    logic [CW-1:0]  r_s_idx, n_s_idx;
    logic [RW-1:0]  r_s_r, n_s_r;
    logic [CLW-1:0] r_s_c, n_s_c;
    logic [EW-1:0]  r_cur, n_cur;
    logic [EW-1:0]  r_nb, n_nb;
    logic [2:0]     r_k, n_k;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_best, n_best;

    logic           w_push, w_pop, w_empty, w_found;
    logic [EW-1:0]  w_wdata, w_rdata;
    logic [AW-1:0]  w_cur_idx;
    logic [RW-1:0]  w_cur_r, w_nr;
    logic [CLW-1:0] w_cur_c, w_nc;
    logic [AW-1:0]  w_off_r, w_off_c, w_n;
    logic           w_row_ok, w_col_ok, w_nb_ok, w_last_k, w_scan_end;

    assign w_cur_idx  = r_cur[EW-1 -: AW];
    assign w_cur_r    = r_cur[CLW +: RW];
    assign w_cur_c    = r_cur[CLW-1:0];
    assign w_found    = i_grid_q && !i_vis_q;
    assign w_last_k   = (r_k == 3'd7);
    assign w_scan_end = (r_s_idx == i_total);

    // neighbor row bound and index offset
    always_comb begin
        case (lbs_pkg::nb_dr(r_k))
            lbs_pkg::STEP_INC: begin
                w_row_ok = (XW'(w_cur_r) + XW'(1)) != XW'(i_rows);
                w_nr     = w_cur_r + RW'(1);
                w_off_r  = AW'(i_cols);
            end
            lbs_pkg::STEP_DEC: begin
                w_row_ok = (w_cur_r != '0);
                w_nr     = w_cur_r - RW'(1);
                w_off_r  = AW'(0) - AW'(i_cols);
            end
            default: begin
                w_row_ok = 1'b1;
                w_nr     = w_cur_r;
                w_off_r  = '0;
            end
        endcase
    end

    // neighbor column bound and index offset
    always_comb begin
        case (lbs_pkg::nb_dc(r_k))
            lbs_pkg::STEP_INC: begin
                w_col_ok = (XW'(w_cur_c) + XW'(1)) != XW'(i_cols);
                w_nc     = w_cur_c + CLW'(1);
                w_off_c  = AW'(1);
            end
            lbs_pkg::STEP_DEC: begin
                w_col_ok = (w_cur_c != '0);
                w_nc     = w_cur_c - CLW'(1);
                w_off_c  = AW'(0) - AW'(1);
            end
            default: begin
                w_col_ok = 1'b1;
                w_nc     = w_cur_c;
                w_off_c  = '0;
            end
        endcase
    end

    assign w_n     = w_cur_idx + w_off_r + w_off_c;
    assign w_nb_ok = w_row_ok && w_col_ok;

    lbs_stack #(
        .DEPTH (CELLS),
        .DW    (EW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lbs_pkg::S_IDLE: begin
                if (i_go) n_state = lbs_pkg::S_SCAN;
            end
            lbs_pkg::S_SCAN: begin
                n_state = w_scan_end ? lbs_pkg::S_DONE : lbs_pkg::S_SCAN_CHK;
            end
            lbs_pkg::S_SCAN_CHK: begin
                n_state = w_found ? lbs_pkg::S_POP : lbs_pkg::S_SCAN;
            end
            lbs_pkg::S_POP: begin
                n_state = w_empty ? lbs_pkg::S_SCAN : lbs_pkg::S_POP_WAIT;
            end
            lbs_pkg::S_POP_WAIT: begin
                n_state = lbs_pkg::S_NB;
            end
            lbs_pkg::S_NB: begin
                if (w_nb_ok) begin
                    n_state = lbs_pkg::S_NB_CHK;
                end else if (w_last_k) begin
                    n_state = lbs_pkg::S_POP;
                end
            end
            lbs_pkg::S_NB_CHK: begin
                n_state = w_last_k ? lbs_pkg::S_POP : lbs_pkg::S_NB;
            end
            lbs_pkg::S_DONE: begin
                n_state = lbs_pkg::S_IDLE;
            end
            default: n_state = lbs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_raddr     = w_n;
        o_waddr     = r_nb[EW-1 -: AW];
        o_vis_we    = 1'b0;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_wdata     = r_nb;
        o_stat.active = (r_state != lbs_pkg::S_IDLE);
        o_stat.done   = (r_state == lbs_pkg::S_DONE);
        case (r_state)
            lbs_pkg::S_SCAN: begin
                o_raddr = AW'(r_s_idx);
            end
            lbs_pkg::S_SCAN_CHK: begin
                o_waddr  = AW'(r_s_idx);
                o_vis_we = w_found;
                w_push   = w_found;
                w_wdata  = {AW'(r_s_idx), r_s_r, r_s_c};
            end
            lbs_pkg::S_POP: begin
                w_pop = !w_empty;
            end
            lbs_pkg::S_NB_CHK: begin
                o_vis_we = w_found;
                w_push   = w_found;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_s_idx = r_s_idx;
        n_s_r   = r_s_r;
        n_s_c   = r_s_c;
        n_cur   = r_cur;
        n_nb    = r_nb;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_best  = r_best;
        case (r_state)
            lbs_pkg::S_IDLE: begin
                if (i_go) begin
                    n_s_idx = '0;
                    n_s_r   = '0;
                    n_s_c   = '0;
                    n_best  = '0;
                end
            end
            lbs_pkg::S_SCAN_CHK: begin
                n_s_idx = r_s_idx + CW'(1);
                if ((XW'(r_s_c) + XW'(1)) == XW'(i_cols)) begin
                    n_s_c = '0;
                    n_s_r = r_s_r + RW'(1);
                end else begin
                    n_s_c = r_s_c + CLW'(1);
                end
                if (w_found) n_cnt = '0;
            end
            lbs_pkg::S_POP: begin
                if (w_empty) begin
                    if (r_cnt > r_best) n_best = r_cnt;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            lbs_pkg::S_POP_WAIT: begin
                n_cur = w_rdata;
                n_k   = '0;
            end
            lbs_pkg::S_NB: begin
                if (w_nb_ok) begin
                    n_nb = {w_n, w_nr, w_nc};
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            lbs_pkg::S_NB_CHK: begin
                n_k = r_k + 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_idx <= n_s_idx;
        r_s_r   <= n_s_r;
        r_s_c   <= n_s_c;
        r_cur   <= n_cur;
        r_nb    <= n_nb;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_best  <= n_best;
    end

    assign o_best = r_best;

endmodule

// ===== hdl/largest_blob_size_8conn.sv =====
// Largest 8-connected blob size: top level with APB registers, frame loader and result output.
//
// Cells load one per cycle (start high, busy low) in raster order until grid_rows x
// grid_cols cells are in. The block then raises busy and searches the frame with a
// single sequencer, one memory access per step. Each scanned cell passes a scan state
// and a check state. Each set cell is popped and read back, then its eight neighbors
// are visited, with a check state for each in-bounds one; each blob closes on an empty
// pop. The result is on o_largest_size under o_valid, which is high for one cycle, and
// busy drops in that same cycle. o_largest_size holds the result until the next frame's
// result. The visited map is cleared as cells load, so no clearing pass is needed.
module largest_blob_size_8conn #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [lbs_pkg::APB_W-1:0]     pwdata,
    output logic [lbs_pkg::APB_W-1:0]     prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cell_set,
    output logic                          o_valid,
    output logic [lbs_pkg::OUT_W-1:0]     o_largest_size
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int PW    = 2 * lbs_pkg::CFG_W;
    localparam int SW    = (CW > lbs_pkg::OUT_W) ? CW : lbs_pkg::OUT_W;

    logic [lbs_pkg::CFG_W-1:0] r_grid_rows, r_grid_cols;
    logic [lbs_pkg::CFG_W-1:0] w_rows, w_cols, w_reg_rd;
    logic [PW-1:0]             w_prod;
    logic [CW-1:0]             w_total, w_lp_next, w_best;
    logic [AW-1:0]             r_lp;
    logic                      r_busy, r_go, r_valid;
    logic [lbs_pkg::OUT_W-1:0] r_size;
    logic [SW-1:0]             w_best_w;
    logic                      w_acc, w_last, w_cfg_wr;

    logic [AW-1:0]             s_raddr, s_waddr, w_waddr;
    logic                      s_vis_we, w_grid_q, w_vis_q;
    lbs_pkg::t_srch_stat       s_stat;
    lbs_pkg::t_mem_wr          w_mem_wr;

    // APB registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            lbs_pkg::REG_ROWS: w_reg_rd = r_grid_rows;
            lbs_pkg::REG_COLS: w_reg_rd = r_grid_cols;
            default:           w_reg_rd = '0;
        endcase
    end

    assign prdata = lbs_pkg::APB_W'(w_reg_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lbs_pkg::GRID_DIM_RST;
            r_grid_cols <= lbs_pkg::GRID_DIM_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                lbs_pkg::REG_ROWS: r_grid_rows <= pwdata[lbs_pkg::CFG_W-1:0];
                lbs_pkg::REG_COLS: r_grid_cols <= pwdata[lbs_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // dimensions in use, clamped to 1..MAX
    always_comb begin
        if (r_grid_rows == '0) begin
            w_rows = lbs_pkg::CFG_W'(1);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            w_rows = lbs_pkg::CFG_W'(MAX_ROWS);
        end else begin
            w_rows = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            w_cols = lbs_pkg::CFG_W'(1);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            w_cols = lbs_pkg::CFG_W'(MAX_COLS);
        end else begin
            w_cols = r_grid_cols;
        end
    end

    assign w_prod  = PW'(w_rows) * PW'(w_cols);
    assign w_total = CW'(w_prod);

    // frame loader
    assign w_acc     = start && !busy;
    assign w_lp_next = CW'(r_lp) + CW'(1);
    assign w_last    = (w_lp_next >= w_total);

    assign w_best_w = SW'(w_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp    <= '0;
            r_busy  <= 1'b0;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go    <= w_acc && w_last;
            r_valid <= s_stat.done;
            if (w_acc) begin
                r_lp <= w_last ? '0 : AW'(w_lp_next);
            end
            if (w_acc && w_last) begin
                r_busy <= 1'b1;
            end else if (s_stat.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_stat.done) begin
            r_size <= (w_best_w > SW'(lbs_pkg::SIZE_SAT)) ? lbs_pkg::SIZE_SAT
                                                           : lbs_pkg::OUT_W'(w_best_w);
        end
    end

    assign busy           = r_busy;
    assign o_valid        = r_valid;
    assign o_largest_size = r_size;

    // loading clears the visited bit of each cell it writes
    always_comb begin
        w_mem_wr.grid_we = w_acc;
        w_mem_wr.vis_we  = w_acc || s_vis_we;
        w_mem_wr.grid_d  = i_cell_set;
        w_mem_wr.vis_d   = !w_acc;
        w_waddr          = w_acc ? r_lp : s_waddr;
    end

    lbs_cell_mem #(
        .DEPTH (CELLS)
    ) u_cell_mem (
        .i_clk    (i_clk),
        .i_wr     (w_mem_wr),
        .i_waddr  (w_waddr),
        .i_raddr  (s_raddr),
        .o_grid_q (w_grid_q),
        .o_vis_q  (w_vis_q)
    );

    lbs_search #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_go),
        .i_rows   (w_rows),
        .i_cols   (w_cols),
        .i_total  (w_total),
        .i_grid_q (w_grid_q),
        .i_vis_q  (w_vis_q),
        .o_raddr  (s_raddr),
        .o_waddr  (s_waddr),
        .o_vis_we (s_vis_we),
        .o_stat   (s_stat),
        .o_best   (w_best)
    );

`ifndef SYNTHESIS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a search in progress");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("more than one result per frame");

    a_search_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_vis_we |-> (busy && !w_acc))
        else $error("visited map written by search outside a search");

    a_go_idle_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> !s_stat.active)
        else $error("search started while one is running");
`endif

endmodule
